>>> design/tssc_pkg.sv
// tssc_pkg: shared constants, controller states and the command/status
// structs of the target sum sign counter. Depends on nothing.

package tssc_pkg;

	localparam int WAYS_W           = 33;
	localparam int TARGET_W         = 11;
	localparam int MAX_TOTAL_DEF    = 1023;
	localparam int MAX_ITEMS_DEF    = 32;
	localparam int ELEMENT_BITS_DEF = 8;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_READ,
		ST_CAPT
	} tssc_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept;
		logic sweep_step;
		logic drain;
		logic rd_tgt;
		logic load_out;
		logic clr_step;
	} tssc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic apply;
		logic idx_last;
	} tssc_sts_t;

endpackage

>>> design/tssc_in_if.sv
// tssc_in_if: valid/ready channel for element requests.
// Depends on tssc_pkg.

interface tssc_in_if import tssc_pkg::*; #(
	parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
);
	logic                    valid;
	logic                    ready;
	logic [ELEMENT_BITS-1:0] element_value;
	logic                    is_last;

	modport source (output valid, output element_value, output is_last, input ready);
	modport sink   (input valid, input element_value, input is_last, output ready);
endinterface

>>> design/tssc_out_if.sv
// tssc_out_if: valid/ready channel for result requests.
// Depends on tssc_pkg.

interface tssc_out_if import tssc_pkg::*;;
	logic              valid;
	logic              ready;
	logic [WAYS_W-1:0] ways;
	logic              overflow;

	modport source (output valid, output ways, output overflow, input ready);
	modport sink   (input valid, input ways, input overflow, output ready);
endinterface

>>> design/tssc_ram.sv
// tssc_ram: one write port, two registered read ports.
// No dependencies.

module tssc_ram #(
	parameter int DEPTH = 2047,
	parameter int AW    = 11,
	parameter int DW    = 33
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr0,
	input  logic [AW-1:0] raddr1,
	output logic [DW-1:0] rdata0,
	output logic [DW-1:0] rdata1
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

>>> design/tssc_dp.sv
// tssc_dp: datapath with the two count banks, sweep index, set counters,
// target register and result register. Depends on tssc_pkg and tssc_ram.

module tssc_dp import tssc_pkg::*; #(
	parameter int MAX_TOTAL    = MAX_TOTAL_DEF,
	parameter int MAX_ITEMS    = MAX_ITEMS_DEF,
	parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tssc_cmd_t               cmd,
	output tssc_sts_t               sts,
	input  logic [ELEMENT_BITS-1:0] elem_value,
	input  logic                    cfg_we,
	input  logic [TARGET_W-1:0]     cfg_wdata,
	output logic [WAYS_W-1:0]       ways,
	output logic                    overflow
);

	localparam int SPAN  = 2 * MAX_TOTAL + 1;
	localparam int IDX_W = $clog2(SPAN);
	localparam int TOT_W = $clog2(MAX_TOTAL + 1);
	localparam int CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int AW    = ((IDX_W > ELEMENT_BITS) ? IDX_W : ELEMENT_BITS) + 1;
	localparam int SW    = ((TOT_W > ELEMENT_BITS) ? TOT_W : ELEMENT_BITS) + 1;
	localparam int TW    = ((TARGET_W > TOT_W) ? TARGET_W : TOT_W) + 2;

	logic [TARGET_W-1:0]     target_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [TOT_W-1:0]        total_q;
	logic                    ovf_q;
	logic [ELEMENT_BITS-1:0] elem_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    cur_q;
	logic                    wr_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic                    lo_ok_s1;
	logic                    hi_ok_s1;
	logic [WAYS_W-1:0]       ways_q;
	logic                    ovf_out_q;

	logic [SW-1:0]           tot_sum;
	logic [AW-1:0]           idx_ext;
	logic [AW-1:0]           elem_ext;
	logic [AW-1:0]           hi_sum;
	logic                    lo_ok;
	logic                    hi_ok;
	logic [IDX_W-1:0]        lo_addr;
	logic [IDX_W-1:0]        hi_addr;
	logic signed [TW-1:0]    tgt_sum;
	logic                    tgt_ok;
	logic [IDX_W-1:0]        tgt_addr;
	logic [IDX_W-1:0]        raddr0;
	logic                    re;
	logic                    we0;
	logic                    we1;
	logic [IDX_W-1:0]        waddr;
	logic [WAYS_W-1:0]       wdata;
	logic [WAYS_W-1:0]       clr_data;
	logic [WAYS_W-1:0]       b0_rd0, b0_rd1, b1_rd0, b1_rd1;
	logic [WAYS_W-1:0]       rd_lo;
	logic [WAYS_W-1:0]       rd_hi;
	logic [WAYS_W-1:0]       sweep_sum;

	// admission check for a new element
	assign tot_sum = SW'(total_q) + SW'(elem_value);
	assign sts.apply = !ovf_q && (cnt_q != CNT_W'(MAX_ITEMS)) &&
		(tot_sum <= SW'(MAX_TOTAL));
	assign sts.idx_last = (idx_q == IDX_W'(SPAN - 1));

	// neighbor addresses s-v and s+v
	assign idx_ext  = AW'(idx_q);
	assign elem_ext = AW'(elem_q);
	assign hi_sum   = idx_ext + elem_ext;
	assign lo_ok    = (idx_ext >= elem_ext);
	assign hi_ok    = (hi_sum < AW'(SPAN));
	assign lo_addr  = IDX_W'(idx_ext - elem_ext);
	assign hi_addr  = hi_sum[IDX_W-1:0];

	// target entry, offset by the zero-sum position
	assign tgt_sum  = TW'($signed(target_q)) + TW'(MAX_TOTAL);
	assign tgt_ok   = !tgt_sum[TW-1] && (tgt_sum[TW-2:0] < (TW-1)'(SPAN));
	assign tgt_addr = tgt_sum[IDX_W-1:0];

	assign raddr0 = cmd.rd_tgt ? tgt_addr : lo_addr;
	assign re     = cmd.sweep_step || cmd.rd_tgt;

	assign rd_lo     = cur_q ? b1_rd0 : b0_rd0;
	assign rd_hi     = cur_q ? b1_rd1 : b0_rd1;
	assign sweep_sum = WAYS_W'((lo_ok_s1 ? rd_lo : '0) + (hi_ok_s1 ? rd_hi : '0));
	assign clr_data  = (idx_q == IDX_W'(MAX_TOTAL)) ? WAYS_W'(1) : '0;

	// sweep writes the other bank, clearing writes the live one
	assign we0   = (wr_s1 && cur_q) || (cmd.clr_step && !cur_q);
	assign we1   = (wr_s1 && !cur_q) || (cmd.clr_step && cur_q);
	assign waddr = wr_s1 ? idx_s1 : idx_q;
	assign wdata = wr_s1 ? sweep_sum : clr_data;

	tssc_ram #(.DEPTH(SPAN), .AW(IDX_W), .DW(WAYS_W)) u_bank0 (
		.clk    (clk),
		.we     (we0),
		.waddr  (waddr),
		.wdata  (wdata),
		.re     (re),
		.raddr0 (raddr0),
		.raddr1 (hi_addr),
		.rdata0 (b0_rd0),
		.rdata1 (b0_rd1)
	);

	tssc_ram #(.DEPTH(SPAN), .AW(IDX_W), .DW(WAYS_W)) u_bank1 (
		.clk    (clk),
		.we     (we1),
		.waddr  (waddr),
		.wdata  (wdata),
		.re     (re),
		.raddr0 (raddr0),
		.raddr1 (hi_addr),
		.rdata0 (b1_rd0),
		.rdata1 (b1_rd1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			cnt_q    <= '0;
			total_q  <= '0;
			ovf_q    <= 1'b0;
			idx_q    <= '0;
			cur_q    <= 1'b0;
			wr_s1    <= 1'b0;
		end else begin
			if (cfg_we) begin
				target_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				if (sts.apply) begin
					cnt_q   <= cnt_q + CNT_W'(1);
					total_q <= TOT_W'(tot_sum);
				end else if (!ovf_q) begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.load_out) begin
				cnt_q   <= '0;
				total_q <= '0;
				ovf_q   <= 1'b0;
			end
			if (cmd.sweep_step || cmd.clr_step) begin
				idx_q <= sts.idx_last ? '0 : idx_q + IDX_W'(1);
			end
			if (cmd.drain) begin
				cur_q <= ~cur_q;
			end
			wr_s1 <= cmd.sweep_step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			elem_q <= elem_value;
		end
		idx_s1   <= idx_q;
		lo_ok_s1 <= lo_ok;
		hi_ok_s1 <= hi_ok;
		if (cmd.load_out) begin
			ways_q    <= (ovf_q || !tgt_ok) ? '0 : rd_lo;
			ovf_out_q <= ovf_q;
		end
	end

	assign ways     = ways_q;
	assign overflow = ovf_out_q;

endmodule

>>> design/tssc_ctrl.sv
// tssc_ctrl: controller state machine and result valid flag.
// Depends on tssc_pkg.

module tssc_ctrl import tssc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_last,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  tssc_sts_t sts,
	output tssc_cmd_t cmd
);

	tssc_state_t state_q, state_nxt;
	logic        last_q;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.idx_last) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (sts.apply) state_nxt = ST_SWEEP;
					else if (in_last) state_nxt = ST_READ;
				end
			end
			ST_SWEEP: begin
				if (sts.idx_last) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_nxt = last_q ? ST_READ : ST_IDLE;
			end
			ST_READ: begin
				state_nxt = ST_CAPT;
			end
			ST_CAPT: begin
				if (out_free) state_nxt = ST_CLEAR;
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: cmd.clr_step = 1'b1;
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_SWEEP: cmd.sweep_step = 1'b1;
			ST_DRAIN: cmd.drain = 1'b1;
			ST_READ: cmd.rd_tgt = 1'b1;
			ST_CAPT: cmd.load_out = out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.accept) begin
				last_q <= in_last;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> design/target_sum_sign_count_unit.sv
// target_sum_sign_count_unit: per element an accept step, a sweep of the 2*MAX_TOTAL+1 count
// entries at one per cycle and a drain step; the sweep rate is set by the single write port
// of the count bank being built. a last request adds a read of the target entry, a capture
// that waits for a free result slot and a pass over the 2*MAX_TOTAL+1 entries that restores
// the count store; ignored elements skip the sweep; after arst_n the same restore pass runs
// before the first request. Depends on tssc_pkg, the two ifs, ctrl, dp.

module target_sum_sign_count_unit import tssc_pkg::*; #(
	parameter int MAX_TOTAL    = MAX_TOTAL_DEF,
	parameter int MAX_ITEMS    = MAX_ITEMS_DEF,
	parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	tssc_in_if.sink             elem,
	tssc_out_if.source          result,
	input  logic                cfg_we,
	input  logic [TARGET_W-1:0] cfg_wdata
);

	// command and status between controller and datapath
	tssc_cmd_t cmd;
	tssc_sts_t sts;

	// controller: sequences accept, sweep, drain, target read, result capture and restore pass
	tssc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (elem.valid),
		.in_last   (elem.is_last),
		.in_ready  (elem.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: two ping-pong count banks, each sweep reads s-v and s+v from
	// the live bank and writes their sum into the other one
	tssc_dp #(
		.MAX_TOTAL    (MAX_TOTAL),
		.MAX_ITEMS    (MAX_ITEMS),
		.ELEMENT_BITS (ELEMENT_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.elem_value (ELEMENT_BITS'(elem.element_value)),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.ways       (result.ways),
		.overflow   (result.overflow)
	);

endmodule

>>> tb/tb_target_sum_sign_count_unit.sv
// tb_target_sum_sign_count_unit: self-checking bench for the target sum sign counter,
// a directed list of element sets followed by random sets, every count checked in order.
// Depends on tssc_pkg, tssc_in_if, tssc_out_if and target_sum_sign_count_unit.

module tb_target_sum_sign_count_unit;
	import tssc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_TOTAL = MAX_TOTAL_DEF;
	localparam int MAX_ITEMS = MAX_ITEMS_DEF;
	localparam int SPAN      = 2 * MAX_TOTAL + 1;
	localparam int ITEM_GOAL = 290;   // element requests that actually fold into the store
	localparam int PHASE_ITEMS = 36;  // folded elements per target setting in the random part
	localparam int DIR_ROWS  = 24;

	// one expected result request
	typedef struct packed {
		logic [WAYS_W-1:0] ways;
		logic              overflow;
	} count_res_t;

	// one row of the directed list; typed rows carry a count that is obvious by hand
	typedef struct packed {
		bit                  wr_tgt;
		logic [TARGET_W-1:0] tgt;
		logic [7:0]          value;
		bit                  last;
		bit                  typed;
		logic [WAYS_W-1:0]   ways;
		bit                  ovf;
	} dir_row_t;

	logic                clk    = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we;
	logic [TARGET_W-1:0] cfg_wdata;

	tssc_in_if #(.ELEMENT_BITS(ELEMENT_BITS_DEF)) elem_if ();
	tssc_out_if result_if ();

	target_sum_sign_count_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.elem      (elem_if.sink),
		.result    (result_if.source),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// in-bench copy of the count store and the per-set bookkeeping
	logic [WAYS_W-1:0]   sum_ways [SPAN];
	int                  set_items;
	int                  set_total;
	bit                  set_ovf;
	logic [TARGET_W-1:0] tgt_q;
	int                  applied_items = 0;

	count_res_t          count_q [$];   // counts still owed by the block, oldest first
	int                  mismatches    = 0;
	int                  sets_checked  = 0;
	int                  overflow_sets = 0;
	logic [WAYS_W-1:0]   biggest_count = '0;

	// directed list: zero element, extremes of value and target, the total overflow path,
	// an ignored element after overflow and a target outside the store
	dir_row_t dir_rows [DIR_ROWS] = '{
		// target 0 after reset: a lone zero counts twice
		'{1'b0, 11'sd0,     8'd0,   1'b1, 1'b1, 33'd2, 1'b0},
		// a lone 255 cannot land on zero
		'{1'b0, 11'sd0,     8'd255, 1'b1, 1'b1, 33'd0, 1'b0},
		'{1'b1, 11'sd255,   8'd255, 1'b1, 1'b1, 33'd1, 1'b0},
		// largest positive target: all plus signs, total exactly at the bound
		'{1'b1, 11'sd1023,  8'd255, 1'b0, 1'b0, 33'd0, 1'b0},
		'{1'b0, 11'sd0,     8'd255, 1'b0, 1'b0, 33'd0, 1'b0},
		'{1'b0, 11'sd0,     8'd255, 1'b0, 1'b0, 33'd0, 1'b0},
		'{1'b0, 11'sd0,     8'd255, 1'b0, 1'b0, 33'd0, 1'b0},
		'{1'b0, 11'sd0,     8'd3,   1'b1, 1'b1, 33'd1, 1'b0},
		// most negative target in the store: all minus signs
		'{1'b1, -11'sd1023, 8'd255, 1'b0, 1'b0, 33'd0, 1'b0},
		'{1'b0, 11'sd0,     8'd255, 1'b0, 1'b0, 33'd0, 1'b0},
		'{1'b0, 11'sd0,     8'd255, 1'b0, 1'b0, 33'd0, 1'b0},
		'{1'b0, 11'sd0,     8'd255, 1'b0, 1'b0, 33'd0, 1'b0},
		'{1'b0, 11'sd0,     8'd3,   1'b1, 1'b1, 33'd1, 1'b0},
		// running total one past the bound, then an element that is ignored
		'{1'b0, 11'sd0,     8'd255, 1'b0, 1'b0, 33'd0, 1'b0},
		'{1'b0, 11'sd0,     8'd255, 1'b0, 1'b0, 33'd0, 1'b0},
		'{1'b0, 11'sd0,     8'd255, 1'b0, 1'b0, 33'd0, 1'b0},
		'{1'b0, 11'sd0,     8'd255, 1'b0, 1'b0, 33'd0, 1'b0},
		'{1'b0, 11'sd0,     8'd4,   1'b0, 1'b0, 33'd0, 1'b0},
		'{1'b0, 11'sd0,     8'd7,   1'b1, 1'b1, 33'd0, 1'b1},
		// target of -1024 lies outside the store
		'{1'b1, -11'sd1024, 8'd3,   1'b0, 1'b0, 33'd0, 1'b0},
		'{1'b0, 11'sd0,     8'd5,   1'b1, 1'b1, 33'd0, 1'b0},
		// small mixed set, predicted
		'{1'b1, 11'sd2,     8'd1,   1'b0, 1'b0, 33'd0, 1'b0},
		'{1'b0, 11'sd0,     8'd1,   1'b0, 1'b0, 33'd0, 1'b0},
		'{1'b0, 11'sd0,     8'd0,   1'b1, 1'b0, 33'd0, 1'b0}
	};

	// mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// start of a set: one way to reach sum zero
	function automatic void clear_sums();
		foreach (sum_ways[s])
			sum_ways[s] = '0;
		sum_ways[MAX_TOTAL] = 1;
		set_items = 0;
		set_total = 0;
		set_ovf   = 1'b0;
	endfunction

	// folds one accepted element into the count store; returns 1 with the count
	// when the element closes its set
	function automatic bit fold_element(input logic [7:0] v, input bit last,
			output count_res_t res);
		logic [WAYS_W-1:0] nxt [SPAN];
		logic [WAYS_W-1:0] lo;
		logic [WAYS_W-1:0] hi;
		int                vi;
		int                t;
		vi  = int'(v);
		res = '0;
		// once overflow is seen the rest of the set leaves the store alone
		if (!set_ovf) begin
			if (set_items + 1 > MAX_ITEMS || set_total + vi > MAX_TOTAL) begin
				set_ovf = 1'b1;
			end else begin
				set_items++;
				set_total += vi;
				applied_items++;
				// each sum is reached from s-v with a plus and from s+v with a minus
				for (int s = 0; s < SPAN; s++) begin
					lo = (s - vi >= 0) ? sum_ways[s - vi] : '0;
					hi = (s + vi < SPAN) ? sum_ways[s + vi] : '0;
					nxt[s] = lo + hi;
				end
				sum_ways = nxt;
			end
		end
		if (!last)
			return 1'b0;
		t = $signed(tgt_q);
		res.overflow = set_ovf;
		if (set_ovf || t < -MAX_TOTAL || t > MAX_TOTAL)
			res.ways = '0;
		else
			res.ways = sum_ways[t + MAX_TOTAL];
		clear_sums();
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("%0t ns: mismatch: %s", $time, msg);
	endtask

	// one element request; valid stays high across back-to-back requests
	task automatic send_elem(input logic [7:0] v, input bit last, input bit typed,
			input count_res_t typed_res);
		int         gap;
		count_res_t res;
		gap = pick_gap();
		if (gap != 0) begin
			elem_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		elem_if.valid         <= 1'b1;
		elem_if.element_value <= v;
		elem_if.is_last       <= last;
		@(posedge clk);
		while (!elem_if.ready)
			@(posedge clk);
		// accepted at this edge: predict now, keep the typed count where there is one
		if (fold_element(v, last, res))
			count_q.push_back(typed ? typed_res : res);
	endtask

	// sender holds off until every count is back and the restore sweep is over
	task automatic settle();
		elem_if.valid <= 1'b0;
		while (count_q.size() != 0)
			@(posedge clk);
		repeat (SPAN + 8) @(posedge clk);
	endtask

	task automatic write_target(input logic [TARGET_W-1:0] t);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= t;
		@(posedge clk);
		cfg_we    <= 1'b0;
		tgt_q      = t;
	endtask

	// one random set: mostly small values that land on small targets, some sets
	// of big values that may run past the total bound, and some plain noise
	task automatic send_set();
		int         r;
		int         len;
		logic [7:0] v;
		r = $urandom_range(0, 99);
		if (r < 70)
			len = $urandom_range(1, 8);
		else if (r < 88)
			len = $urandom_range(3, 7);
		else
			len = $urandom_range(1, 3);
		for (int i = 0; i < len; i++) begin
			if (r < 70)
				v = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
					: 8'($urandom_range(0, 15));
			else if (r < 88)
				v = 8'($urandom_range(100, 255));
			else
				v = 8'($urandom_range(0, 255));
			send_elem(v, i == len - 1, 1'b0, '0);
		end
	endtask

	// result side: stall windows of varying density, including windows with no stall
	initial begin
		int hold_left;
		int window_left;
		int stall_pct;
		hold_left   = 0;
		window_left = 0;
		stall_pct   = 0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (window_left == 0) begin
				window_left = $urandom_range(200, 1500);
				case ($urandom_range(0, 2))
					0: stall_pct = 0;
					1: stall_pct = 20;
					default: stall_pct = 60;
				endcase
			end else begin
				window_left--;
			end
			if (!arst_n) begin
				result_if.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left--;
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
				if ($urandom_range(0, 99) < stall_pct)
					hold_left = pick_gap();
			end
		end
	end

	// result checker: each accepted result against the oldest owed count
	always @(posedge clk) begin
		count_res_t want;
		if (arst_n && result_if.valid && result_if.ready) begin
			if (count_q.size() == 0) begin
				report_mismatch($sformatf("result with no count pending (ways %0d overflow %0b)",
					result_if.ways, result_if.overflow));
			end else begin
				want = count_q.pop_front();
				sets_checked++;
				if (result_if.overflow)
					overflow_sets++;
				if (result_if.ways > biggest_count)
					biggest_count = result_if.ways;
				if (result_if.ways !== want.ways)
					report_mismatch($sformatf("ways %0d, expected %0d",
						result_if.ways, want.ways));
				if (result_if.overflow !== want.overflow)
					report_mismatch($sformatf("overflow %0b, expected %0b",
						result_if.overflow, want.overflow));
			end
		end
	end

	// run limit, far above the slowest legal run
	initial begin
		#40_000_000;
		$display("tb_target_sum_sign_count_unit failed");
		$finish;
	end

	initial begin
		int                  phase;
		int                  phase_start;
		logic [TARGET_W-1:0] tgt_pick;
		elem_if.valid         <= 1'b0;
		elem_if.element_value <= '0;
		elem_if.is_last       <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_wdata             <= '0;
		clear_sums();
		tgt_q = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed list; the block runs its restore sweep first and holds ready low
		foreach (dir_rows[k]) begin
			if (dir_rows[k].wr_tgt)
				write_target(dir_rows[k].tgt);
			send_elem(dir_rows[k].value, dir_rows[k].last, dir_rows[k].typed,
				'{dir_rows[k].ways, dir_rows[k].ovf});
		end

		// random part, one target per phase; phase 0 carries the largest possible
		// count and phase 3 a set that runs past the element limit
		phase = 0;
		while (applied_items < ITEM_GOAL) begin
			case (phase % 4)
				1: tgt_pick = TARGET_W'($urandom_range(0, 2047));
				2: begin
					case ((phase / 4) % 3)
						0: tgt_pick = 11'sd1023;
						1: tgt_pick = -11'sd1023;
						default: tgt_pick = -11'sd1024;
					endcase
				end
				default: tgt_pick = TARGET_W'($urandom_range(0, 40) - 20);
			endcase
			if (phase == 0)
				tgt_pick = '0;
			write_target(tgt_pick);
			phase_start = applied_items;
			if (phase == 0) begin
				// MAX_ITEMS zeros: every sign choice sums to zero, 2^32 ways
				for (int i = 0; i < MAX_ITEMS; i++)
					send_elem(8'd0, i == MAX_ITEMS - 1, 1'b0, '0);
			end
			if (phase == 3) begin
				// one element past the limit, then one more that is ignored
				for (int i = 0; i < MAX_ITEMS + 2; i++)
					send_elem(8'($urandom_range(0, 3)), i == MAX_ITEMS + 1, 1'b0, '0);
			end
			while (applied_items - phase_start < PHASE_ITEMS && applied_items < ITEM_GOAL)
				send_set();
			phase++;
		end

		// drain: every count back, then let the last restore sweep finish
		elem_if.valid <= 1'b0;
		while (count_q.size() != 0)
			@(posedge clk);
		repeat (SPAN + 16) @(posedge clk);

		$display("covered %0d folded element requests in %0d sets over %0d random phases",
			applied_items, sets_checked, phase);
		$display("%0d sets overflowed, largest count seen %0d", overflow_sets, biggest_count);
		if (mismatches == 0) begin
			$display("tb_target_sum_sign_count_unit passed");
		end else begin
			$display("tb_target_sum_sign_count_unit failed");
		end
		$finish;
	end

endmodule
